### rtl/core/assert_macros.svh
// Concurrent assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

### rtl/core/iiee_pkg.sv
package iiee_pkg;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EQUAL = 8'h3D;

	// pending multiplicative operator of the current term
	typedef enum logic [1:0] {
		MP_NONE,
		MP_MUL,
		MP_DIV
	} mp_t;

	// operator character being processed
	typedef enum logic [2:0] {
		CLS_MUL,
		CLS_DIV,
		CLS_PLUS,
		CLS_MINUS,
		CLS_EQUAL
	} cls_t;

	typedef enum logic {
		MD_MUL,
		MD_DIV
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} md_sts_t;

endpackage

### rtl/core/iiee_char_if.sv
interface iiee_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

### rtl/core/iiee_result_if.sv
interface iiee_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               div_by_zero;

	modport source (output valid, output value, output div_by_zero, input ready);
	modport sink (input valid, input value, input div_by_zero, output ready);
endinterface

### rtl/core/iiee_muldiv.sv
module iiee_muldiv #(
	parameter int WORD_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iiee_pkg::md_req_t      req,
	input  logic [WORD_BITS-1:0]   a,
	input  logic [WORD_BITS-1:0]   b,
	output iiee_pkg::md_sts_t      sts,
	output logic [WORD_BITS-1:0]   result
);
	import iiee_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

	// acc: product or partial remainder; x: multiplicand or dividend/quotient;
	// y: multiplier or divisor
	logic [WORD_BITS-1:0] acc_q, x_q, y_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q, done_q;
	md_op_t               op_q;

	logic [WORD_BITS+1:0] add_a, add_b, add_sum;
	logic                 cin;
	logic                 ge;

	always_comb begin
		if (op_q == MD_MUL) begin
			add_a = {2'b00, acc_q};
			add_b = {2'b00, x_q};
			cin   = 1'b0;
		end else begin
			add_a = {1'b0, acc_q, x_q[WORD_BITS-1]};
			add_b = ~{2'b00, y_q};
			cin   = 1'b1;
		end
		add_sum = add_a + add_b + {{(WORD_BITS+1){1'b0}}, cin};
		// top bit of the subtract is the borrow: clear when shifted remainder >= divisor
		ge = !add_sum[WORD_BITS+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= MD_MUL;
		end else begin
			done_q <= 1'b0;
			if (!busy_q && req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			acc_q <= '0;
			x_q   <= a;
			y_q   <= b;
		end else if (busy_q) begin
			if (op_q == MD_MUL) begin
				if (y_q[0])
					acc_q <= add_sum[WORD_BITS-1:0];
				x_q <= {x_q[WORD_BITS-2:0], 1'b0};
				y_q <= {1'b0, y_q[WORD_BITS-1:1]};
			end else begin
				if (ge) begin
					acc_q <= add_sum[WORD_BITS-1:0];
					x_q   <= {x_q[WORD_BITS-2:0], 1'b1};
				end else begin
					acc_q <= {acc_q[WORD_BITS-2:0], x_q[WORD_BITS-1]};
					x_q   <= {x_q[WORD_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = (op_q == MD_MUL) ? acc_q : x_q;

endmodule

### rtl/core/infix_integer_expression_evaluator.sv
// Streaming evaluator for integer infix expressions over + - * / with the
// usual precedence, one character per transaction. An operator is folded in
// a fold state and a post state, with a wait state between them when a
// multiply or divide is pending on the current term (but not when the pending
// divide has a zero divisor): the pending operation runs on a single shared
// shift-add / restoring-divide unit that retires one bit per cycle. Input is
// not ready while an operator is being folded. The result of '=' goes to an
// output register; the next expression is accepted while it waits, and only
// a second '=' stalls until the first result is taken.
// Arithmetic wraps at WORD_BITS bits; value carries the low 32 bits of the
// wrapped sum, zero-extended when WORD_BITS is below 32.
module infix_integer_expression_evaluator #(
	parameter int WORD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	iiee_char_if.sink     chars,
	iiee_result_if.source results
);
	import iiee_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FOLD = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_POST = 3'd3;

	logic [2:0]           state_q;
	logic [WORD_BITS-1:0] sum_q, term_q, operand_q;
	logic                 add_neg_q, closed_q, div_err_q, qneg_q;
	mp_t                  mulp_q;
	cls_t                 cls_q;
	logic                 out_valid_q, out_flag_q;
	logic [31:0]          out_value_q;

	md_req_t              md_req;
	md_sts_t              md_sts;
	logic [WORD_BITS-1:0] md_a, md_b, md_res;

	logic                 in_fire, is_digit, out_free;
	logic [3:0]           digit;
	logic [WORD_BITS-1:0] operand_next, sum_next, term_abs, operand_abs;
	logic [WORD_BITS+31:0] sum_ext;

	assign chars.ready = (state_q == ST_IDLE);
	assign in_fire     = chars.valid && chars.ready;
	assign is_digit    = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
	assign digit       = 4'(chars.char_code - CH_ZERO);
	assign operand_next = {operand_q[WORD_BITS-4:0], 3'b000}
		+ {operand_q[WORD_BITS-2:0], 1'b0}
		+ {{(WORD_BITS-4){1'b0}}, digit};

	assign term_abs    = term_q[WORD_BITS-1] ? -term_q : term_q;
	assign operand_abs = operand_q[WORD_BITS-1] ? -operand_q : operand_q;
	assign sum_next    = add_neg_q ? (sum_q - term_q) : (sum_q + term_q);
	assign sum_ext     = {32'd0, sum_next};
	assign out_free    = !out_valid_q || results.ready;

	always_comb begin
		md_req.start = 1'b0;
		md_req.op    = MD_MUL;
		md_a         = term_q;
		md_b         = operand_q;
		if (state_q == ST_FOLD) begin
			if (mulp_q == MP_MUL) begin
				md_req.start = 1'b1;
			end else if (mulp_q == MP_DIV && operand_q != '0) begin
				md_req.start = 1'b1;
				md_req.op    = MD_DIV;
				md_a         = term_abs;
				md_b         = operand_abs;
			end
		end
	end

	iiee_muldiv #(
		.WORD_BITS(WORD_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (md_a),
		.b      (md_b),
		.sts    (md_sts),
		.result (md_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			term_q      <= '0;
			operand_q   <= '0;
			add_neg_q   <= 1'b0;
			closed_q    <= 1'b0;
			div_err_q   <= 1'b0;
			qneg_q      <= 1'b0;
			mulp_q      <= MP_NONE;
			cls_q       <= CLS_PLUS;
			out_valid_q <= 1'b0;
		end else begin
			if (results.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (is_digit) begin
							if (!closed_q)
								operand_q <= operand_next;
						end else begin
							unique case (chars.char_code)
								CH_SPACE: ;
								CH_STAR: begin
									cls_q   <= CLS_MUL;
									state_q <= ST_FOLD;
								end
								CH_SLASH: begin
									cls_q   <= CLS_DIV;
									state_q <= ST_FOLD;
								end
								CH_PLUS: begin
									cls_q   <= CLS_PLUS;
									state_q <= ST_FOLD;
								end
								CH_MINUS: begin
									cls_q   <= CLS_MINUS;
									state_q <= ST_FOLD;
								end
								CH_EQUAL: begin
									cls_q   <= CLS_EQUAL;
									state_q <= ST_FOLD;
								end
								default: closed_q <= 1'b1;
							endcase
						end
					end
				end
				ST_FOLD: begin
					operand_q <= '0;
					closed_q  <= 1'b0;
					qneg_q    <= term_q[WORD_BITS-1] ^ operand_q[WORD_BITS-1];
					case (mulp_q)
						MP_MUL: state_q <= ST_WAIT;
						MP_DIV: begin
							if (operand_q == '0) begin
								div_err_q <= 1'b1;
								state_q   <= ST_POST;
							end else begin
								state_q <= ST_WAIT;
							end
						end
						default: begin
							term_q  <= operand_q;
							state_q <= ST_POST;
						end
					endcase
				end
				ST_WAIT: begin
					if (md_sts.done) begin
						if (mulp_q == MP_DIV && qneg_q)
							term_q <= -md_res;
						else
							term_q <= md_res;
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					case (cls_q) inside
						CLS_MUL: begin
							mulp_q  <= MP_MUL;
							state_q <= ST_IDLE;
						end
						CLS_DIV: begin
							mulp_q  <= MP_DIV;
							state_q <= ST_IDLE;
						end
						CLS_PLUS, CLS_MINUS: begin
							sum_q     <= sum_next;
							term_q    <= '0;
							mulp_q    <= MP_NONE;
							add_neg_q <= (cls_q == CLS_MINUS);
							state_q   <= ST_IDLE;
						end
						default: begin
							// wait for the output register before emitting
							if (out_free) begin
								out_valid_q <= 1'b1;
								sum_q       <= '0;
								term_q      <= '0;
								mulp_q      <= MP_NONE;
								add_neg_q   <= 1'b0;
								div_err_q   <= 1'b0;
								state_q     <= ST_IDLE;
							end
						end
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_POST && cls_q == CLS_EQUAL && out_free) begin
			out_value_q <= sum_ext[31:0];
			out_flag_q  <= div_err_q;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.value       = out_value_q;
	assign results.div_by_zero = out_flag_q;

`include "assert_macros.svh"

	`ASSERT_IMP(a_unit_busy_in_wait, clk, arst_n, md_sts.busy, state_q == ST_WAIT)
	`ASSERT_NXT(a_done_to_post, clk, arst_n, (state_q == ST_WAIT) && md_sts.done,
		state_q == ST_POST)
	`ASSERT_NXT(a_fold_clears_operand, clk, arst_n, state_q == ST_FOLD,
		(operand_q == '0) && !closed_q)
	`ASSERT_NXT(a_emit_clears_state, clk, arst_n,
		(state_q == ST_POST) && (cls_q == CLS_EQUAL) && out_free,
		out_valid_q && (sum_q == '0) && (term_q == '0) && !div_err_q)

endmodule

### bench/tb_infix_integer_expression_evaluator.sv
`timescale 1ns / 1ps

module tb_infix_integer_expression_evaluator;
	import iiee_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RANDOM_CHARS   = 750;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;

	typedef struct packed {
		logic [31:0] value;
		logic        div_by_zero;
	} eval_result_t;

	logic clk;
	logic arst_n;

	iiee_char_if   chars_if ();
	iiee_result_if results_if ();

	infix_integer_expression_evaluator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if.sink),
		.results(results_if.source)
	);

	// evaluator state as seen from outside
	logic [31:0] sum_q;
	logic [31:0] term_q;
	logic [31:0] opnd_q;
	logic        sub_q;
	mp_t         mul_pend_q;
	logic        closed_q;
	logic        dz_q;

	eval_result_t expected_results[$];
	int           mismatches;
	int           chars_accepted;
	int           idle_cycles;
	bit           back_to_back;
	int           ready_hold;
	int unsigned  ready_roll;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [31:0] trunc_quotient(logic [31:0] num, logic [31:0] den);
		logic [31:0] mag_n;
		logic [31:0] mag_d;
		logic [31:0] q;
		mag_n = num[31] ? -num : num;
		mag_d = den[31] ? -den : den;
		q     = mag_n / mag_d;
		return (num[31] ^ den[31]) ? -q : q;
	endfunction

	function automatic void clear_eval_state();
		sum_q      = '0;
		term_q     = '0;
		opnd_q     = '0;
		sub_q      = 1'b0;
		mul_pend_q = MP_NONE;
		closed_q   = 1'b0;
		dz_q       = 1'b0;
	endfunction

	function automatic void fold_operand();
		if (mul_pend_q == MP_MUL) begin
			term_q = term_q * opnd_q;
		end else if (mul_pend_q == MP_DIV) begin
			// divide by zero keeps the term and latches the flag
			if (opnd_q == '0) begin
				dz_q = 1'b1;
			end else begin
				term_q = trunc_quotient(term_q, opnd_q);
			end
		end else begin
			term_q = opnd_q;
		end
		opnd_q   = '0;
		closed_q = 1'b0;
	endfunction

	function automatic void fold_term();
		sum_q      = sub_q ? sum_q - term_q : sum_q + term_q;
		term_q     = '0;
		mul_pend_q = MP_NONE;
	endfunction

	function automatic void predict_char(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (!closed_q)
				opnd_q = opnd_q * 10 + 32'(c - CH_ZERO);
		end else begin
			case (c) inside
				CH_SPACE: ;
				CH_STAR, CH_SLASH: begin
					fold_operand();
					mul_pend_q = (c == CH_STAR) ? MP_MUL : MP_DIV;
				end
				CH_PLUS, CH_MINUS: begin
					fold_operand();
					fold_term();
					sub_q = (c == CH_MINUS);
				end
				CH_EQUAL: begin
					fold_operand();
					fold_term();
					expected_results.push_back(eval_result_t'{value: sum_q,
						div_by_zero: dz_q});
					clear_eval_state();
				end
				default: closed_q = 1'b1;
			endcase
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic int pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (back_to_back || roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// valid stays high after a transaction; a pause must lower it first
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		do @(posedge clk); while (!chars_if.ready);
		predict_char(c);
		chars_accepted++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic wait_results_drained();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic string operand_text();
		int unsigned       roll;
		longint unsigned   v;
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			v = $urandom_range(0, 9);
		end else if (roll < 55) begin
			v = $urandom_range(10, 9999);
		end else if (roll < 75) begin
			v = $urandom;
		end else if (roll < 85) begin
			case ($urandom_range(0, 3))
				0: v = 64'd2147483647;
				1: v = 64'd2147483648;
				2: v = 64'd4294967295;
				default: v = 64'd0;
			endcase
		end else if (roll < 95) begin
			v = $urandom_range(0, 2);
		end else begin
			// long digit runs wrap the operand
			return $sformatf("%0d%0d", $urandom, $urandom);
		end
		return $sformatf("%0d", v);
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	task automatic maybe_space();
		if ($urandom_range(0, 9) == 0)
			send_char(CH_SPACE);
	endtask

	task automatic send_random_expr();
		int terms;
		terms = $urandom_range(1, 6);
		for (int t = 0; t < terms; t++) begin
			maybe_space();
			if ($urandom_range(0, 99) >= 4)
				send_text(operand_text());
			if ($urandom_range(0, 99) < 5) begin
				send_char(8'($urandom_range(0, 255)));
				send_text(operand_text());
			end
			maybe_space();
			if (t == terms - 1)
				send_char(CH_EQUAL);
			else
				send_char(pick_operator());
		end
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 8);
		repeat (n) send_char(8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_precedence();
		send_text("12+3*4-5=");
		send_text("-7/2=");
	endtask

	task automatic test_division_corners();
		send_text("9/0*2=");
		send_text("2147483648/4294967295=");
		send_text("4294967295*7/2=");
	endtask

	task automatic test_wraparound();
		send_text("99999999999+2147483647+1=");
	endtask

	task automatic test_stray_chars();
		send_text("1 2x3");
		send_char(8'hFF);
		send_text("4+*=");
		send_char(CH_EQUAL);
	endtask

	task automatic test_random_expressions();
		bit paused;
		paused = 1'b0;
		while (chars_accepted < RANDOM_CHARS) begin
			back_to_back = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				send_noise();
			else
				send_random_expr();
			if (!paused && chars_accepted > RANDOM_CHARS / 2) begin
				wait_results_drained();
				paused = 1'b1;
			end
		end
		back_to_back = 1'b0;
	endtask

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin : result_check
		eval_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: value %0d div_by_zero %0b",
					results_if.value, results_if.div_by_zero);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (results_if.value !== want.value) begin
					$error("value: expected %0d, got %0d", $signed(want.value),
						results_if.value);
					mismatches++;
				end
				if (results_if.div_by_zero !== want.div_by_zero) begin
					$error("div_by_zero: expected %0b, got %0b", want.div_by_zero,
						results_if.div_by_zero);
					mismatches++;
				end
			end
		end
	end

	// result back-pressure: mostly ready, short stalls, now and then a long one
	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			ready_hold       <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 55) begin
				results_if.ready <= 1'b1;
				ready_hold       <= $urandom_range(0, 15);
			end else if (ready_roll < 92) begin
				results_if.ready <= 1'b0;
				ready_hold       <= $urandom_range(0, 3);
			end else begin
				results_if.ready <= 1'b0;
				ready_hold       <= $urandom_range(15, 50);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (chars_if.valid && chars_if.ready) ||
				(results_if.valid && results_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n             = 1'b0;
		chars_if.valid     = 1'b0;
		chars_if.char_code = '0;
		results_if.ready   = 1'b0;
		mismatches         = 0;
		chars_accepted     = 0;
		idle_cycles        = 0;
		back_to_back       = 1'b0;
		ready_hold         = 0;
		clear_eval_state();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_precedence();
		test_division_corners();
		test_wraparound();
		test_stray_chars();
		wait_results_drained();
		test_random_expressions();

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/iiee_pkg.sv
rtl/core/iiee_char_if.sv
rtl/core/iiee_result_if.sv
rtl/core/iiee_muldiv.sv
rtl/core/infix_integer_expression_evaluator.sv
bench/tb_infix_integer_expression_evaluator.sv
